[design/ksts_pkg.sv]
// Shared types and constants for the kth smallest triplet sum block.
// No dependencies.
`default_nettype none
package ksts_pkg;
    localparam int MAX_ELEMENTS = 512;
    localparam int ELEM_W       = 27;
    localparam int SUM_W        = 29;
    localparam int TALLY_W      = 25;
    localparam int IDX_W        = $clog2(MAX_ELEMENTS);
    localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);

    typedef struct packed {
        logic              valid;
        logic [ELEM_W-1:0] value;
    } cell_t;

    typedef struct packed {
        logic insert;
        logic shift;
        logic clear;
    } chain_ctl_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CLEAR,
        ST_UNLOAD,
        ST_SETUP,
        ST_CHECK,
        ST_ROW,
        ST_LATCH,
        ST_ISSUE,
        ST_EVAL,
        ST_DECIDE,
        ST_OUT
    } state_t;
endpackage
`default_nettype wire

[design/ksts_cell.sv]
// One sorter cell: holds one element, inserts in order, shifts toward the head or clears.
// Depends on ksts_pkg.
`default_nettype none
module ksts_cell
    import ksts_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire chain_ctl_t        ctl,
    input  wire logic [ELEM_W-1:0] x,
    input  wire cell_t             prev,
    input  wire logic              prev_gt,
    input  wire cell_t             next,
    output cell_t                  cur,
    output logic                   gt
);
    logic              valid_reg;
    logic [ELEM_W-1:0] value_reg;
    cell_t             cell_next;

    // empty cells count as larger than anything
    assign gt  = !valid_reg || (value_reg > x);
    assign cur = '{valid: valid_reg, value: value_reg};

    always_comb
    begin
        cell_next = '{valid: valid_reg, value: value_reg};
        if (ctl.clear)
        begin
            cell_next.valid = 1'b0;
        end
        else if (ctl.shift)
        begin
            cell_next = next;
        end
        else if (ctl.insert && gt)
        begin
            if (prev_gt)
                cell_next = prev;
            else
                cell_next = '{valid: 1'b1, value: x};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= cell_next.valid;
    end

    always_ff @(posedge clk)
    begin
        value_reg <= cell_next.value;
    end
endmodule
`default_nettype wire

[design/ksts_chain.sv]
// Row of sorter cells; cell 0 holds the smallest element.
// Depends on ksts_pkg, ksts_cell.
`default_nettype none
module ksts_chain
    import ksts_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire chain_ctl_t        ctl,
    input  wire logic [ELEM_W-1:0] x,
    output cell_t                  head
);
    cell_t cells [MAX_ELEMENTS];
    logic  gts   [MAX_ELEMENTS];

    genvar k;
    generate
        for (k = 0; k < MAX_ELEMENTS; k++)
        begin : g_cell
            cell_t prev_c, next_c;
            logic  prev_g;
            if (k == 0)
            begin : g_first
                assign prev_c = '0;
                assign prev_g = 1'b0;
            end
            else
            begin : g_mid
                assign prev_c = cells[k-1];
                assign prev_g = gts[k-1];
            end
            if (k == MAX_ELEMENTS - 1)
            begin : g_last
                assign next_c = '0;
            end
            else
            begin : g_nmid
                assign next_c = cells[k+1];
            end
            ksts_cell u_cell (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .x       (x),
                .prev    (prev_c),
                .prev_gt (prev_g),
                .next    (next_c),
                .cur     (cells[k]),
                .gt      (gts[k])
            );
        end
    endgenerate

    assign head = cells[0];
endmodule
`default_nettype wire

[design/ksts_ctrl.sv]
// Load/unload sequencing, sorted-element memory and the binary search over sums.
// Depends on ksts_pkg.
`default_nettype none
module ksts_ctrl
    import ksts_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_accept,
    input  wire logic [TALLY_W-1:0] in_rank,
    input  wire logic               in_last,
    output logic                    in_ready,
    input  wire cell_t              head,
    output chain_ctl_t              ctl,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [SUM_W-1:0]        out_sum,
    output logic                    out_err
);
    state_t state_reg, state_next;

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [TALLY_W-1:0] rank_reg, rank_next;
    logic [ELEM_W-1:0]  s0_reg, s1_reg, s2_reg, s0_next, s1_next, s2_next;
    logic [ELEM_W-1:0]  t0_reg, t1_reg, t2_reg, t0_next, t1_next, t2_next;
    logic [SUM_W-1:0]   low_reg, low_next, high_reg, high_next;
    logic [SUM_W-1:0]   best_reg, best_next, probe_reg, probe_next;
    logic [TALLY_W-1:0] tally_reg, tally_next;
    logic [IDX_W-1:0]   i_reg, i_next, lo_reg, lo_next, hi_reg, hi_next;
    logic [ELEM_W-1:0]  ai_reg, ai_next;
    logic               res_err_reg, res_err_next;
    logic               ov_reg, ov_next;
    logic [SUM_W-1:0]   osum_reg, osum_next;
    logic               oerr_reg, oerr_next;

    // sorted elements
    logic [ELEM_W-1:0] mem [MAX_ELEMENTS];
    logic              we;
    logic [IDX_W-1:0]  wa, addr_a, addr_b;
    logic [ELEM_W-1:0] rd_a_reg, rd_b_reg;

    logic [CNT_W-1:0] cnt_inc;
    logic [SUM_W-1:0] trip_sum;
    logic             row_ok, slot_free, reached;

    assign cnt_inc   = cnt_reg + ((cnt_reg < CNT_W'(MAX_ELEMENTS)) ? CNT_W'(1) : CNT_W'(0));
    assign trip_sum  = SUM_W'(ai_reg) + SUM_W'(rd_a_reg) + SUM_W'(rd_b_reg);
    assign row_ok    = (CNT_W'(i_reg) + CNT_W'(2)) < n_reg;
    assign slot_free = !ov_reg || out_ready;
    assign reached   = tally_reg >= rank_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= head.value;
        rd_a_reg <= mem[addr_a];
        rd_b_reg <= mem[addr_b];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
                if (in_accept && in_last)
                    state_next = (cnt_inc < CNT_W'(3)) ? ST_CLEAR : ST_UNLOAD;
            ST_CLEAR:  state_next = ST_OUT;
            ST_UNLOAD:
                if (cnt_reg == n_reg - CNT_W'(1))
                    state_next = ST_SETUP;
            ST_SETUP:  state_next = ST_CHECK;
            ST_CHECK:  state_next = (low_reg <= high_reg) ? ST_ROW : ST_OUT;
            ST_ROW:    state_next = row_ok ? ST_LATCH : ST_DECIDE;
            ST_LATCH:  state_next = ST_ISSUE;
            ST_ISSUE:  state_next = (lo_reg < hi_reg) ? ST_EVAL : ST_ROW;
            ST_EVAL:   state_next = ST_ISSUE;
            ST_DECIDE:
                if (reached && probe_reg == '0)
                    state_next = ST_OUT;
                else
                    state_next = ST_CHECK;
            ST_OUT:
                if (slot_free)
                    state_next = ST_LOAD;
            default:   state_next = ST_LOAD;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        rank_next    = rank_reg;
        s0_next      = s0_reg;
        s1_next      = s1_reg;
        s2_next      = s2_reg;
        t0_next      = t0_reg;
        t1_next      = t1_reg;
        t2_next      = t2_reg;
        low_next     = low_reg;
        high_next    = high_reg;
        best_next    = best_reg;
        probe_next   = probe_reg;
        tally_next   = tally_reg;
        i_next       = i_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        ai_next      = ai_reg;
        res_err_next = res_err_reg;
        ov_next      = ov_reg && !out_ready;
        osum_next    = osum_reg;
        oerr_next    = oerr_reg;
        ctl          = '0;
        we           = 1'b0;
        wa           = cnt_reg[IDX_W-1:0];
        addr_a       = lo_reg;
        addr_b       = hi_reg;
        in_ready     = (state_reg == ST_LOAD);

        case (state_reg)
            ST_LOAD:
                if (in_accept)
                begin
                    ctl.insert = (cnt_reg < CNT_W'(MAX_ELEMENTS));
                    cnt_next   = cnt_inc;
                    if (in_last)
                    begin
                        n_next    = cnt_inc;
                        cnt_next  = '0;
                        rank_next = in_rank;
                    end
                end
            ST_CLEAR:
            begin
                ctl.clear    = 1'b1;
                best_next    = '0;
                res_err_next = 1'b1;
            end
            ST_UNLOAD:
            begin
                we        = 1'b1;
                ctl.shift = 1'b1;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(0)) s0_next = head.value;
                if (cnt_reg == CNT_W'(1)) s1_next = head.value;
                if (cnt_reg == CNT_W'(2)) s2_next = head.value;
                t0_next = head.value;
                t1_next = t0_reg;
                t2_next = t1_reg;
            end
            ST_SETUP:
            begin
                low_next     = SUM_W'(s0_reg) + SUM_W'(s1_reg) + SUM_W'(s2_reg);
                high_next    = SUM_W'(t0_reg) + SUM_W'(t1_reg) + SUM_W'(t2_reg);
                best_next    = SUM_W'(s0_reg) + SUM_W'(s1_reg) + SUM_W'(s2_reg);
                res_err_next = 1'b0;
            end
            ST_CHECK:
            begin
                probe_next = low_reg + ((high_reg - low_reg) >> 1);
                tally_next = '0;
                i_next     = '0;
            end
            ST_ROW:
            begin
                addr_a  = i_reg;
                lo_next = i_reg + IDX_W'(1);
                hi_next = IDX_W'(n_reg - CNT_W'(1));
            end
            ST_LATCH:  ai_next = rd_a_reg;
            ST_ISSUE:
                if (!(lo_reg < hi_reg))
                    i_next = i_reg + IDX_W'(1);
            ST_EVAL:
                if (trip_sum <= probe_reg)
                begin
                    tally_next = tally_reg + TALLY_W'(hi_reg - lo_reg);
                    lo_next    = lo_reg + IDX_W'(1);
                end
                else
                begin
                    hi_next = hi_reg - IDX_W'(1);
                end
            ST_DECIDE:
                if (reached)
                begin
                    best_next = probe_reg;
                    high_next = probe_reg - SUM_W'(1);
                end
                else
                begin
                    low_next = probe_reg + SUM_W'(1);
                end
            ST_OUT:
                if (slot_free)
                begin
                    ov_next   = 1'b1;
                    osum_next = best_reg;
                    oerr_next = res_err_reg;
                    cnt_next  = '0;
                end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            n_reg       <= '0;
            low_reg     <= '0;
            high_reg    <= '0;
            best_reg    <= '0;
            tally_reg   <= '0;
            res_err_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            n_reg       <= n_next;
            low_reg     <= low_next;
            high_reg    <= high_next;
            best_reg    <= best_next;
            tally_reg   <= tally_next;
            res_err_reg <= res_err_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rank_reg  <= rank_next;
        s0_reg    <= s0_next;
        s1_reg    <= s1_next;
        s2_reg    <= s2_next;
        t0_reg    <= t0_next;
        t1_reg    <= t1_next;
        t2_reg    <= t2_next;
        probe_reg <= probe_next;
        i_reg     <= i_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        ai_reg    <= ai_next;
        osum_reg  <= osum_next;
        oerr_reg  <= oerr_next;
    end

    assign out_valid = ov_reg;
    assign out_sum   = osum_reg;
    assign out_err   = oerr_reg;
endmodule
`default_nettype wire

[design/kth_smallest_triplet_sum.sv]
// Operation: elements load one per cycle; a last transaction unloads the sorted cell
// row into memory, then runs a binary search over sums whose probes each count
// triplets by two-pointer steps (one memory read pair per step). Fewer than 3 elements: error.
// Throughput: one transaction per cycle while loading; one set at a time.
// Reset: asynchronous active low; clears control state and empties the cell row.
`default_nettype none
module kth_smallest_triplet_sum
    import ksts_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // element [26:0], rank [51:27], zero pad
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // selected_sum [28:0], zero pad
    output logic             m_tuser    // too_few_elements
);
    chain_ctl_t       ctl;
    cell_t            head;
    logic [SUM_W-1:0] sum;

    ksts_chain u_chain (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .x     (s_tdata[ELEM_W-1:0]),
        .head  (head)
    );

    ksts_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_accept  (s_tvalid && s_tready),
        .in_rank    (s_tdata[ELEM_W+TALLY_W-1:ELEM_W]),
        .in_last    (s_tlast),
        .in_ready   (s_tready),
        .head       (head),
        .ctl        (ctl),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sum    (sum),
        .out_err    (m_tuser)
    );

    assign m_tdata = {{(32-SUM_W){1'b0}}, sum};
endmodule
`default_nettype wire

[design/ksts_checker.sv]
// Port-level checks for kth_smallest_triplet_sum, bound to the top level.
// Depends on kth_smallest_triplet_sum ports only.
`default_nettype none
module ksts_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata,
    input wire logic        m_tuser
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == 32'd0)
        else $error("error result with nonzero sum");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input taken during search");

    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast |=> s_tready)
        else $error("ready dropped while loading");
endmodule

bind kth_smallest_triplet_sum ksts_checker u_ksts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire
